// File: src/adaptive_first_order_lowpass_defines.svh
// ---------------------------------------------------------------------------
// adaptive first-order lowpass assertion macros
// concurrent assertion forms for the filter modules
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_FIRST_ORDER_LOWPASS_DEFINES_SVH
`define ADAPTIVE_FIRST_ORDER_LOWPASS_DEFINES_SVH

// clocked property, off while reset is held
`define AFOL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset too
`define AFOL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/afol_pkg.sv
// ---------------------------------------------------------------------------
// afol_pkg
// widths, register indexes and shared types of the adaptive lowpass filter
// ---------------------------------------------------------------------------
package afol_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 8;
    localparam int COEF_WIDTH     = COEF_FRAC_BITS + 1;
    localparam int DIFF_WIDTH     = SAMPLE_WIDTH + 1;
    localparam int PROD_WIDTH     = COEF_WIDTH + 1 + DIFF_WIDTH;
    localparam int SUM_WIDTH      = PROD_WIDTH + 1;

    // register field widths
    localparam int CNT_THR_WIDTH  = 10;
    localparam int STEP_WIDTH     = 9;
    localparam int DEV_THR_WIDTH  = 16;
    localparam int BURST_WIDTH    = 8;
    localparam int RUN_WIDTH      = 11;
    localparam int DEV_CMP_WIDTH  = (DIFF_WIDTH > DEV_THR_WIDTH) ? DIFF_WIDTH : DEV_THR_WIDTH;

    // configuration port
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COUNT_THRESHOLD     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_STEP           = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEVIATION_THRESHOLD = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BURST_INCREMENT     = 2'd3;

    // register reset values
    localparam logic [CNT_THR_WIDTH-1:0] RST_COUNT_THRESHOLD     = 10'd30;
    localparam logic [STEP_WIDTH-1:0]    RST_COEF_STEP           = 9'd51;
    localparam logic [DEV_THR_WIDTH-1:0] RST_DEVIATION_THRESHOLD = 16'd8;
    localparam logic [BURST_WIDTH-1:0]   RST_BURST_INCREMENT     = 8'd5;

    // 1.0 in coefficient format
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << COEF_FRAC_BITS);

    typedef struct packed {
        logic [CNT_THR_WIDTH-1:0] count_threshold;
        logic [STEP_WIDTH-1:0]    coef_step;
        logic [DEV_THR_WIDTH-1:0] deviation_threshold;
        logic [BURST_WIDTH-1:0]   burst_increment;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic [COEF_WIDTH-1:0]          coef_used;
    } t_result;

endpackage

// File: src/afol_sample_if.sv
// ---------------------------------------------------------------------------
// afol_sample_if
// valid/ready channel carrying one input sample item
// ---------------------------------------------------------------------------
interface afol_sample_if import afol_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: src/afol_result_if.sv
// ---------------------------------------------------------------------------
// afol_result_if
// valid/ready channel carrying one filtered result item
// ---------------------------------------------------------------------------
interface afol_result_if import afol_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic [COEF_WIDTH-1:0]          coef_used;

    modport source (output valid, output filtered, output coef_used, input ready);
    modport sink   (input valid, input filtered, input coef_used, output ready);
endinterface

// File: src/afol_cfg_regs.sv
// ---------------------------------------------------------------------------
// afol_cfg_regs
// write-only configuration registers of the filter
// ---------------------------------------------------------------------------
module afol_cfg_regs import afol_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // register writes, truncated to each field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_threshold     <= RST_COUNT_THRESHOLD;
            r_cfg.coef_step           <= RST_COEF_STEP;
            r_cfg.deviation_threshold <= RST_DEVIATION_THRESHOLD;
            r_cfg.burst_increment     <= RST_BURST_INCREMENT;
        end else if (i_we) begin
            case (i_index)
                REG_COUNT_THRESHOLD: begin
                    r_cfg.count_threshold <= i_data[CNT_THR_WIDTH-1:0];
                end
                REG_COEF_STEP: begin
                    r_cfg.coef_step <= i_data[STEP_WIDTH-1:0];
                end
                REG_DEVIATION_THRESHOLD: begin
                    r_cfg.deviation_threshold <= i_data[DEV_THR_WIDTH-1:0];
                end
                REG_BURST_INCREMENT: begin
                    r_cfg.burst_increment <= i_data[BURST_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/afol_core.sv
// ---------------------------------------------------------------------------
// afol_core
// trend tracking, coefficient adaptation and blend of one sample per cycle while i_accept is high
// ---------------------------------------------------------------------------
module afol_core import afol_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  t_cfg                           i_cfg,
    output t_result                        o_result
);

    logic signed [SAMPLE_WIDTH-1:0] r_last;
    logic [COEF_WIDTH-1:0]          r_coef;
    logic                           r_rising;
    logic [RUN_WIDTH-1:0]           r_run;

    logic signed [SAMPLE_WIDTH-1:0] n_last;
    logic [COEF_WIDTH-1:0]          n_coef;
    logic                           n_rising;
    logic [RUN_WIDTH-1:0]           n_run;

    logic signed [DIFF_WIDTH-1:0]   diff;
    logic [DIFF_WIDTH-1:0]          dev;
    logic                           big_dev;
    logic [RUN_WIDTH-1:0]           run_inc;
    logic [COEF_WIDTH:0]            coef_sum;
    logic signed [PROD_WIDTH-1:0]   prod;
    logic signed [SUM_WIDTH-1:0]    last_scaled;
    logic signed [SUM_WIDTH-1:0]    sum;

    // deviation against the last output
    assign diff = DIFF_WIDTH'(i_sample) - DIFF_WIDTH'(r_last);
    assign dev  = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);
    assign big_dev = DEV_CMP_WIDTH'(dev) > DEV_CMP_WIDTH'(i_cfg.deviation_threshold);

    // run counter step and saturating coefficient step
    assign run_inc  = r_run + RUN_WIDTH'(1)
                    + (big_dev ? RUN_WIDTH'(i_cfg.burst_increment) : RUN_WIDTH'(0));
    assign coef_sum = (COEF_WIDTH + 1)'(r_coef) + (COEF_WIDTH + 1)'(i_cfg.coef_step);

    // next trend state
    always_comb begin
        n_rising = r_rising;
        if (diff > 0) begin
            n_rising = 1'b1;
        end else if (diff < 0) begin
            n_rising = 1'b0;
        end
        n_run  = r_run;
        n_coef = r_coef;
        if (n_rising == r_rising) begin
            n_run = run_inc;
            if (run_inc > RUN_WIDTH'(i_cfg.count_threshold)) begin
                n_run = '0;
                if (coef_sum > (COEF_WIDTH + 1)'(COEF_ONE)) begin
                    n_coef = COEF_ONE;
                end else begin
                    n_coef = coef_sum[COEF_WIDTH-1:0];
                end
            end
        end else begin
            n_run  = '0;
            n_coef = '0;
        end
    end

    // blend as k*(x - y) + y*one, rounded to nearest with ties up
    assign prod        = $signed({1'b0, n_coef}) * diff;
    assign last_scaled = {{(SUM_WIDTH - SAMPLE_WIDTH - COEF_FRAC_BITS){r_last[SAMPLE_WIDTH-1]}},
                          r_last, {COEF_FRAC_BITS{1'b0}}};
    assign sum         = SUM_WIDTH'(prod) + last_scaled
                       + SUM_WIDTH'(1 << (COEF_FRAC_BITS - 1));
    assign n_last      = sum[COEF_FRAC_BITS +: SAMPLE_WIDTH];

    // filter state, updated once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_coef   <= '0;
            r_rising <= 1'b0;
            r_run    <= '0;
        end else if (i_accept) begin
            r_last   <= n_last;
            r_coef   <= n_coef;
            r_rising <= n_rising;
            r_run    <= n_run;
        end
    end

    assign o_result.filtered  = n_last;
    assign o_result.coef_used = n_coef;

endmodule

// File: src/afol_out_buf.sv
// ---------------------------------------------------------------------------
// afol_out_buf
// result register with a skid entry so one more input item is taken while output stalls
// ---------------------------------------------------------------------------
`include "adaptive_first_order_lowpass_defines.svh"

module afol_out_buf import afol_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    out_fire;

    assign out_fire = r_out_valid && i_ready;
    assign o_ready  = !r_skid_valid;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_valid && !i_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_valid) begin
            if (r_out_valid && !i_ready) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // skid entry only ever backs a held result
    `AFOL_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid without result")
    // an item arriving at a stalled output lands in the skid entry
    `AFOL_ASSERT(a_stall_to_skid, i_clk, i_rst_n, (i_valid && o_ready && r_out_valid && !i_ready) |=> r_skid_valid, "stalled item lost")
    // an item arriving at an empty output is shown next cycle
    `AFOL_ASSERT(a_empty_to_out, i_clk, i_rst_n, (i_valid && !r_out_valid) |=> (r_out_valid && !r_skid_valid), "item not shown")

endmodule

// File: src/adaptive_first_order_lowpass.sv
// result: registered once its sample item is accepted, or held in the skid entry while the output stalls
// throughput: one item per cycle while the skid entry is free, set by the registered update of last output,
//   coefficient, trend and run count that feeds the next item
// a skid entry keeps the input ready for one item while the output stalls
// reset: synchronous, clears filter state and restores register defaults
// ---------------------------------------------------------------------------
// adaptive_first_order_lowpass
// first-order lag filter whose blend coefficient grows along a steady trend
// ---------------------------------------------------------------------------
module adaptive_first_order_lowpass import afol_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    afol_sample_if.sink                i_in_ch,
    afol_result_if.source              o_out_ch,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_data;
    logic    in_ready;
    logic    in_accept;

    assign in_accept     = i_in_ch.valid && in_ready;
    assign i_in_ch.ready = in_ready;

    // configuration registers
    afol_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // filter datapath and state
    afol_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_sample (i_in_ch.sample),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // result register and skid entry
    afol_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_accept),
        .i_data  (core_result),
        .o_ready (in_ready),
        .o_valid (o_out_ch.valid),
        .i_ready (o_out_ch.ready),
        .o_data  (out_data)
    );

    assign o_out_ch.filtered  = out_data.filtered;
    assign o_out_ch.coef_used = out_data.coef_used;

endmodule
